/* sv/frms_pkg.sv */
// ----------------------------------------------------------------------------
// frms_pkg: shared constants and types of the frame RMS envelope block
// Field widths, arithmetic constants, register indexes and reduce codes.
// ----------------------------------------------------------------------------
`default_nettype none

package frms_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned DEF_MAX_FRAME_SAMPLES = 4096;
  localparam int unsigned DEF_MAX_GROUP_DIVIDER = 1024;

  // Sample path
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned MAG_W   = 16;
  localparam int unsigned DIG_W   = 4;
  localparam int unsigned MAG_DIG = MAG_W / DIG_W;
  localparam int unsigned DIG_CW  = $clog2(MAG_DIG);
  localparam int unsigned SQR_W   = 2 * MAG_W;
  localparam logic [7:0]  U8_OFFSET = 8'd127;

  // Level search
  localparam int unsigned LVL_W    = 7;
  localparam int unsigned LVL_MAX  = 100;
  localparam int unsigned LBIT_W   = $clog2(LVL_W);
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned SCALE_DIG = SCALE_W / DIG_W;
  localparam logic [SCALE_W-1:0] PCT_SCALE = 16'd10000;
  localparam int unsigned FS2_W    = 30;
  localparam logic [FS2_W-1:0] FS2_U8  = 30'd16129;
  localparam logic [FS2_W-1:0] FS2_S16 = 30'd1073676289;
  localparam int unsigned TSQ_W    = 2 * LVL_W;
  localparam int unsigned TSQ_DIG  = (TSQ_W + DIG_W - 1) / DIG_W;
  localparam int unsigned TSQ_PW   = TSQ_DIG * DIG_W;
  localparam int unsigned TDC_W    = $clog2(TSQ_DIG);

  // Configuration port
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned GDIV_W    = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FORMAT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REDUCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DIVIDER = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    RM_NONE  = 2'd0,
    RM_FIRST = 2'd1,
    RM_PEAK  = 2'd2,
    RM_AVG   = 2'd3
  } reduce_mode_e;

  localparam logic              FMT_RST  = 1'b1;
  localparam logic [GDIV_W-1:0] GDIV_RST = 11'd2;
  localparam logic [GDIV_W-1:0] GDIV_MIN = 11'd2;

endpackage

`default_nettype wire

/* sv/frms_if.sv */
// ----------------------------------------------------------------------------
// frms_if: valid/ready channels of the frame RMS envelope block
// Sample channel (raw sample, frame end flag) and amplitude channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface frms_sample_if import frms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] sample_raw;
  logic             frame_end;

  modport source (output valid, output sample_raw, output frame_end, input ready);
  modport sink   (input valid, input sample_raw, input frame_end, output ready);
endinterface

interface frms_amp_if import frms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] amplitude;

  modport source (output valid, output amplitude, input ready);
  modport sink   (input valid, input amplitude, output ready);
endinterface

`default_nettype wire

/* sv/frms_level.sv */
// ----------------------------------------------------------------------------
// frms_level: digit-serial RMS level search
// Builds 10000*sum and n*FS^2 one digit a cycle, then decides the level one
// bit a trial, each trial a digit-serial multiply of t*t by n*FS^2.
// ----------------------------------------------------------------------------
`default_nettype none

module frms_level import frms_pkg::*; #(
  parameter  int unsigned MAX_FRAME_SAMPLES = DEF_MAX_FRAME_SAMPLES,
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_SAMPLES + 1),
  localparam int unsigned SUM_W = SQR_W - 1 + $clog2(MAX_FRAME_SAMPLES)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             fmt_i,
  input  wire logic [SUM_W-1:0] sum_i,
  input  wire logic [CNT_W-1:0] cnt_i,
  output logic                  done_o,
  output logic [LVL_W-1:0]      level_o
);

  localparam int unsigned CNT_DIG  = (CNT_W + DIG_W - 1) / DIG_W;
  localparam int unsigned PREP_DIG = (CNT_DIG > SCALE_DIG) ? CNT_DIG : SCALE_DIG;
  localparam int unsigned PREP_W   = PREP_DIG * DIG_W;
  localparam int unsigned PDC_W    = $clog2(PREP_DIG);
  localparam int unsigned NUM_W    = SUM_W + SCALE_W;
  localparam int unsigned DEN_W    = CNT_W + FS2_W;
  localparam int unsigned PROD_W   = DEN_W + TSQ_PW;
  localparam int unsigned CMP_W    = (NUM_W > PROD_W) ? NUM_W : PROD_W;

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_PREP = 4'b0010,
    L_SQ   = 4'b0100,
    L_MUL  = 4'b1000
  } lvl_state_e;

  lvl_state_e          state_q, state_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [FS2_W-1:0]    fs2_q, fs2_d;
  logic [PREP_W-1:0]   cnt_sr_q, cnt_sr_d;
  logic [PREP_W-1:0]   scl_sr_q, scl_sr_d;
  logic [NUM_W-1:0]    num_q, num_d;
  logic [DEN_W-1:0]    den_q, den_d;
  logic [TSQ_PW-1:0]   tsq_sr_q, tsq_sr_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic                t_ok_q, t_ok_d;
  logic [LVL_W-1:0]    lvl_q, lvl_d;
  logic [LBIT_W-1:0]   bit_q, bit_d;
  logic [PDC_W-1:0]    pdig_q, pdig_d;
  logic [TDC_W-1:0]    tdig_q, tdig_d;
  logic                done_q, done_d;

  logic [SUM_W+DIG_W-1:0] num_pp;
  logic [FS2_W+DIG_W-1:0] den_pp;
  logic [DEN_W+DIG_W-1:0] prod_pp;
  logic [LVL_W-1:0]       t_w;
  logic [TSQ_W-1:0]       tsq;
  logic [PROD_W-1:0]      prod_acc;

  assign num_pp   = sum_q * scl_sr_q[PREP_W-1 -: DIG_W];
  assign den_pp   = fs2_q * cnt_sr_q[PREP_W-1 -: DIG_W];
  assign prod_pp  = den_q * tsq_sr_q[TSQ_PW-1 -: DIG_W];
  assign t_w      = lvl_q | (LVL_W'(1) << bit_q);
  assign tsq      = t_w * t_w;
  assign prod_acc = (prod_q << DIG_W) + PROD_W'(prod_pp);

  always_comb begin
    state_d  = state_q;
    sum_d    = sum_q;
    fs2_d    = fs2_q;
    cnt_sr_d = cnt_sr_q;
    scl_sr_d = scl_sr_q;
    num_d    = num_q;
    den_d    = den_q;
    tsq_sr_d = tsq_sr_q;
    prod_d   = prod_q;
    t_ok_d   = t_ok_q;
    lvl_d    = lvl_q;
    bit_d    = bit_q;
    pdig_d   = pdig_q;
    tdig_d   = tdig_q;
    done_d   = 1'b0;
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          sum_d    = sum_i;
          fs2_d    = fmt_i ? FS2_S16 : FS2_U8;
          cnt_sr_d = PREP_W'(cnt_i);
          scl_sr_d = PREP_W'(PCT_SCALE);
          num_d    = '0;
          den_d    = '0;
          pdig_d   = '0;
          state_d  = L_PREP;
        end
      end
      L_PREP: begin
        // MSB digit first: shift the partial result, add the next product
        num_d    = (num_q << DIG_W) + NUM_W'(num_pp);
        den_d    = (den_q << DIG_W) + DEN_W'(den_pp);
        cnt_sr_d = cnt_sr_q << DIG_W;
        scl_sr_d = scl_sr_q << DIG_W;
        pdig_d   = pdig_q + 1'b1;
        if (pdig_q == PDC_W'(PREP_DIG - 1)) begin
          lvl_d   = '0;
          bit_d   = LBIT_W'(LVL_W - 1);
          state_d = L_SQ;
        end
      end
      L_SQ: begin
        tsq_sr_d = TSQ_PW'(tsq);
        t_ok_d   = (t_w <= LVL_W'(LVL_MAX));
        prod_d   = '0;
        tdig_d   = '0;
        state_d  = L_MUL;
      end
      L_MUL: begin
        prod_d   = prod_acc;
        tsq_sr_d = tsq_sr_q << DIG_W;
        tdig_d   = tdig_q + 1'b1;
        if (tdig_q == TDC_W'(TSQ_DIG - 1)) begin
          // keep the trial bit when t is within LVL_MAX and t*t*n*FS^2 still fits under 10000*sum
          if (t_ok_q && (CMP_W'(prod_acc) <= CMP_W'(num_q))) begin
            lvl_d = t_w;
          end
          if (bit_q == '0) begin
            done_d  = 1'b1;
            state_d = L_IDLE;
          end else begin
            bit_d   = bit_q - 1'b1;
            state_d = L_SQ;
          end
        end
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    fs2_q    <= fs2_d;
    cnt_sr_q <= cnt_sr_d;
    scl_sr_q <= scl_sr_d;
    num_q    <= num_d;
    den_q    <= den_d;
    tsq_sr_q <= tsq_sr_d;
    prod_q   <= prod_d;
    t_ok_q   <= t_ok_d;
    lvl_q    <= lvl_d;
    bit_q    <= bit_d;
    pdig_q   <= pdig_d;
    tdig_q   <= tdig_d;
  end

  assign done_o  = done_q;
  assign level_o = lvl_q;

endmodule

`default_nettype wire

/* sv/frms_div.sv */
// ----------------------------------------------------------------------------
// frms_div: bit-serial group average divider
// Restoring division of the group total by the group size, one quotient
// bit a cycle; the quotient never exceeds the level range.
// ----------------------------------------------------------------------------
`default_nettype none

module frms_div import frms_pkg::*; #(
  parameter  int unsigned MAX_GROUP_DIVIDER = DEF_MAX_GROUP_DIVIDER,
  localparam int unsigned SZ_W  = $clog2(MAX_GROUP_DIVIDER + 1),
  localparam int unsigned TOT_W = $clog2(LVL_MAX * MAX_GROUP_DIVIDER + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [TOT_W-1:0] total_i,
  input  wire logic [SZ_W-1:0]  size_i,
  output logic                  done_o,
  output logic [LVL_W-1:0]      quot_o
);

  localparam int unsigned DSH_W = SZ_W + LVL_W - 1;
  localparam int unsigned CMP_W = (TOT_W > DSH_W) ? TOT_W : DSH_W;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [TOT_W-1:0]  rem_q, rem_d;
  logic [DSH_W-1:0]  dsh_q, dsh_d;
  logic [LVL_W-1:0]  quot_q, quot_d;
  logic [LBIT_W-1:0] bit_q, bit_d;
  logic              ge;

  assign ge = (CMP_W'(rem_q) >= CMP_W'(dsh_q));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    bit_d  = bit_q;
    if (start_i) begin
      rem_d  = total_i;
      dsh_d  = DSH_W'(size_i) << (LVL_W - 1);
      quot_d = '0;
      bit_d  = LBIT_W'(LVL_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - TOT_W'(dsh_q);
      end
      quot_d = {quot_q[LVL_W-2:0], ge};
      dsh_d  = dsh_q >> 1;
      if (bit_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        bit_d = bit_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
    bit_q  <= bit_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* sv/frame_rms_envelope_decimator_core.sv */
// ----------------------------------------------------------------------------
// frame_rms_envelope_decimator_core: frame RMS amplitude envelope, decimated
// Ordinary sample word: accepted in idle, then 4 digit steps of the 16x4 squarer.
// Frame-end word, after its squarer steps: a step to start the level search, 4 prep
// digits, 7 trial bits (each a square step and 4 multiply digits), a step to hand
// the level over, the divider in average mode and a step to load the output register.
// The amplitude register frees the input side while a word waits at the output.
// Reset (async, active low) clears sums, phase, group and output; config to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_rms_envelope_decimator_core import frms_pkg::*; #(
  parameter int unsigned MAX_FRAME_SAMPLES = DEF_MAX_FRAME_SAMPLES,
  parameter int unsigned MAX_GROUP_DIVIDER = DEF_MAX_GROUP_DIVIDER
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  frms_sample_if.sink               smp_i,
  frms_amp_if.source                amp_o
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int unsigned SUM_W = SQR_W - 1 + $clog2(MAX_FRAME_SAMPLES);
  localparam int unsigned PH_W  = $clog2(MAX_GROUP_DIVIDER);
  localparam int unsigned SZ_W  = $clog2(MAX_GROUP_DIVIDER + 1);
  localparam int unsigned TOT_W = $clog2(LVL_MAX * MAX_GROUP_DIVIDER + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SQR    = 6'b000010,
    S_LSTART = 6'b000100,
    S_LWAIT  = 6'b001000,
    S_DWAIT  = 6'b010000,
    S_EMIT   = 6'b100000
  } core_state_e;

  // Configuration registers
  logic              fmt_q;
  reduce_mode_e      mode_q;
  logic [GDIV_W-1:0] gdiv_q;

  // Sample path and frame accumulators
  core_state_e       state_q, state_d;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic [MAG_W-1:0]  mag_sr_q, mag_sr_d;
  logic [SQR_W-1:0]  sq_q, sq_d;
  logic [DIG_CW-1:0] dig_q, dig_d;
  logic              last_q, last_d;
  logic              acc_q, acc_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // Group state
  logic [PH_W-1:0]   phase_q, phase_d;
  logic [LVL_W-1:0]  first_q, first_d;
  logic [LVL_W-1:0]  peak_q, peak_d;
  logic [TOT_W-1:0]  total_q, total_d;
  logic [SZ_W-1:0]   size_q, size_d;
  logic [LVL_W-1:0]  res_q, res_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [LVL_W-1:0]  out_amp_q, out_amp_d;

  // Unit handshakes
  logic              lvl_start;
  logic              lvl_done;
  logic [LVL_W-1:0]  lvl_level;
  logic              div_start;
  logic              div_done;
  logic [LVL_W-1:0]  div_quot;

  logic              in_acc;
  logic [7:0]        raw_lo;
  logic [MAG_W-1:0]  mag_in;
  logic [MAG_W+DIG_W-1:0] sq_pp;
  logic [SQR_W-1:0]  sq_next;
  logic [GDIV_W-1:0] div_eff;
  logic [GDIV_W-1:0] phase_inc;
  logic [PH_W-1:0]   phase_next;
  logic [LVL_W-1:0]  first_n;
  logic [LVL_W-1:0]  peak_n;
  logic [TOT_W-1:0]  total_n;
  logic [SZ_W-1:0]   size_n;
  logic              out_load;

  assign smp_i.ready = (state_q == S_IDLE);
  assign in_acc      = smp_i.valid && smp_i.ready;

  // Magnitude of the incoming sample: s16 two's complement or u8 around 127
  assign raw_lo = smp_i.sample_raw[7:0];
  always_comb begin
    if (fmt_q) begin
      if (smp_i.sample_raw[RAW_W-1]) begin
        mag_in = MAG_W'(~smp_i.sample_raw + 1'b1);
      end else begin
        mag_in = MAG_W'(smp_i.sample_raw);
      end
    end else if (raw_lo >= U8_OFFSET) begin
      mag_in = MAG_W'(raw_lo - U8_OFFSET);
    end else begin
      mag_in = MAG_W'(U8_OFFSET - raw_lo);
    end
  end

  // Square one 4-bit digit of the magnitude per cycle, MSB digit first
  assign sq_pp   = mag_q * mag_sr_q[MAG_W-1 -: DIG_W];
  assign sq_next = (sq_q << DIG_W) + SQR_W'(sq_pp);

  // Group divider held to its legal range
  always_comb begin
    if (gdiv_q < GDIV_MIN) begin
      div_eff = GDIV_MIN;
    end else if (gdiv_q > GDIV_W'(MAX_GROUP_DIVIDER)) begin
      div_eff = GDIV_W'(MAX_GROUP_DIVIDER);
    end else begin
      div_eff = gdiv_q;
    end
  end

  assign phase_inc  = GDIV_W'(phase_q) + 1'b1;
  assign phase_next = (phase_inc >= div_eff) ? '0 : PH_W'(phase_inc);

  // Group values with the new frame level folded in
  assign first_n = (size_q == '0) ? lvl_level : first_q;
  assign peak_n  = (lvl_level > peak_q) ? lvl_level : peak_q;
  assign total_n = total_q + TOT_W'(lvl_level);
  assign size_n  = size_q + 1'b1;

  assign out_load = (state_q == S_EMIT) && (!out_valid_q || amp_o.ready);

  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    mag_sr_d  = mag_sr_q;
    sq_d      = sq_q;
    dig_d     = dig_q;
    last_d    = last_q;
    acc_d     = acc_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    first_d   = first_q;
    peak_d    = peak_q;
    total_d   = total_q;
    size_d    = size_q;
    res_d     = res_q;
    lvl_start = 1'b0;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mag_d    = mag_in;
          mag_sr_d = mag_in;
          sq_d     = '0;
          dig_d    = '0;
          last_d   = smp_i.frame_end;
          // drop samples past the frame limit, but still honor the frame end
          acc_d    = (cnt_q < CNT_W'(MAX_FRAME_SAMPLES));
          state_d  = S_SQR;
        end
      end
      S_SQR: begin
        sq_d     = sq_next;
        mag_sr_d = mag_sr_q << DIG_W;
        dig_d    = dig_q + 1'b1;
        if (dig_q == DIG_CW'(MAG_DIG - 1)) begin
          if (acc_q) begin
            sum_d = sum_q + SUM_W'(sq_next);
            cnt_d = cnt_q + 1'b1;
          end
          state_d = last_q ? S_LSTART : S_IDLE;
        end
      end
      S_LSTART: begin
        // level unit latches sum and count now; open the next frame
        lvl_start = 1'b1;
        sum_d     = '0;
        cnt_d     = '0;
        state_d   = S_LWAIT;
      end
      S_LWAIT: begin
        if (lvl_done) begin
          phase_d = phase_next;
          if (mode_q == RM_NONE) begin
            first_d = '0;
            peak_d  = '0;
            total_d = '0;
            size_d  = '0;
            res_d   = lvl_level;
            state_d = S_EMIT;
          end else if (phase_q == '0) begin
            // this frame closes the group
            first_d = '0;
            peak_d  = '0;
            total_d = '0;
            size_d  = '0;
            state_d = S_EMIT;
            case (mode_q)
              RM_FIRST: res_d = first_n;
              RM_PEAK:  res_d = peak_n;
              RM_AVG: begin
                div_start = 1'b1;
                state_d   = S_DWAIT;
              end
              default:  res_d = lvl_level;
            endcase
          end else begin
            first_d = first_n;
            peak_d  = peak_n;
            total_d = total_n;
            size_d  = size_n;
            state_d = S_IDLE;
          end
        end
      end
      S_DWAIT: begin
        if (div_done) begin
          res_d   = div_quot;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: load on emit, drop once the word is taken
  always_comb begin
    out_amp_d = out_amp_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_amp_d   = res_q;
    end else if (amp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign amp_o.valid     = out_valid_q;
  assign amp_o.amplitude = out_amp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= FMT_RST;
      mode_q <= RM_NONE;
      gdiv_q <= GDIV_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IDX_FORMAT:  fmt_q  <= cfg_data_i[0];
        CFG_IDX_REDUCE:  mode_q <= reduce_mode_e'(cfg_data_i[MODE_W-1:0]);
        CFG_IDX_DIVIDER: gdiv_q <= cfg_data_i[GDIV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      phase_q     <= '0;
      first_q     <= '0;
      peak_q      <= '0;
      total_q     <= '0;
      size_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      first_q     <= first_d;
      peak_q      <= peak_d;
      total_q     <= total_d;
      size_q      <= size_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    mag_sr_q  <= mag_sr_d;
    sq_q      <= sq_d;
    dig_q     <= dig_d;
    last_q    <= last_d;
    acc_q     <= acc_d;
    res_q     <= res_d;
    out_amp_q <= out_amp_d;
  end

  frms_level #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
  ) u_level (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lvl_start),
    .fmt_i   (fmt_q),
    .sum_i   (sum_q),
    .cnt_i   (cnt_q),
    .done_o  (lvl_done),
    .level_o (lvl_level)
  );

  frms_div #(
    .MAX_GROUP_DIVIDER (MAX_GROUP_DIVIDER)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .total_i (total_n),
    .size_i  (size_n),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

`ifndef SYNTH
  a_amp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_amp_q <= LVL_W'(LVL_MAX)))
    else $error("amplitude word above full scale");

  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_FRAME_SAMPLES))
    else $error("frame sample count past its limit");

  a_lvl_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_done |-> (state_q == S_LWAIT))
    else $error("level result arrived outside the level wait");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DWAIT))
    else $error("average result arrived outside the divider wait");
`endif

endmodule

`default_nettype wire
